// ===== sv/hac_pkg.sv =====
// Shared types, constants and register map for the heading alignment rate controller.
`timescale 1ns / 1ps

package hac_pkg;

    localparam int CfgIndexWidth = 3;
    localparam int CfgDataWidth  = 16;
    localparam int InDataWidth   = 40;
    localparam int OutDataWidth  = 24;

    typedef enum logic [CfgIndexWidth-1:0] {
        REG_PROP_GAIN       = 3'd0,
        REG_DAMP_GAIN       = 3'd1,
        REG_MIN_RATE        = 3'd2,
        REG_MIN_RAMP_GAIN   = 3'd3,
        REG_MAX_RATE        = 3'd4,
        REG_MAX_RATE_STEP   = 3'd5,
        REG_ALIGN_TOLERANCE = 3'd6
    } hac_reg_index_t;

    localparam logic [15:0] PropGainReset       = 16'd1024;
    localparam logic [15:0] DampGainReset       = 16'd77;
    localparam logic [14:0] MinRateReset        = 15'd492;
    localparam logic [15:0] MinRampGainReset    = 16'd683;
    localparam logic [14:0] MaxRateReset        = 15'd7373;
    localparam logic [14:0] MaxRateStepReset    = 15'd1638;
    localparam logic [13:0] AlignToleranceReset = 14'd61;

    typedef struct packed {
        logic [15:0] prop_gain;
        logic [15:0] damp_gain;
        logic [14:0] min_rate;
        logic [15:0] min_ramp_gain;
        logic [14:0] max_rate;
        logic [14:0] max_rate_step;
        logic [13:0] align_tolerance;
    } hac_cfg_t;

    typedef struct packed {
        logic signed [14:0] heading_error;
        logic signed [15:0] yaw_rate;
        logic               gyro_fresh;
        logic               hold;
    } hac_item_t;

    typedef struct packed {
        logic signed [30:0] prop_term;
        logic signed [31:0] damp_term;
        logic        [30:0] ramp_term;
        logic               ramp_band;
        logic               aligned;
        logic               force_zero;
    } hac_prod_t;

    typedef struct packed {
        logic signed [32:0] acc;
        logic        [14:0] floor_rate;
        logic               aligned;
        logic               force_zero;
    } hac_acc_t;

    typedef struct packed {
        logic signed [15:0] cmd;
        logic               aligned;
        logic               force_zero;
    } hac_cmd_t;

endpackage

// ===== sv/hac_cfg.sv =====
// Configuration register file for the rate controller gains and limits.
`timescale 1ns / 1ps

module hac_cfg (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [hac_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [hac_pkg::CfgDataWidth-1:0]    cfg_data,
    output hac_pkg::hac_cfg_t                   cfg
);

    hac_pkg::hac_cfg_t cfg_reg;
    hac_pkg::hac_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                hac_pkg::REG_PROP_GAIN:       cfg_next.prop_gain       = cfg_data;
                hac_pkg::REG_DAMP_GAIN:       cfg_next.damp_gain       = cfg_data;
                hac_pkg::REG_MIN_RATE:        cfg_next.min_rate        = cfg_data[14:0];
                hac_pkg::REG_MIN_RAMP_GAIN:   cfg_next.min_ramp_gain   = cfg_data;
                hac_pkg::REG_MAX_RATE:        cfg_next.max_rate        = cfg_data[14:0];
                hac_pkg::REG_MAX_RATE_STEP:   cfg_next.max_rate_step   = cfg_data[14:0];
                hac_pkg::REG_ALIGN_TOLERANCE: cfg_next.align_tolerance = cfg_data[13:0];
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain       <= hac_pkg::PropGainReset;
            cfg_reg.damp_gain       <= hac_pkg::DampGainReset;
            cfg_reg.min_rate        <= hac_pkg::MinRateReset;
            cfg_reg.min_ramp_gain   <= hac_pkg::MinRampGainReset;
            cfg_reg.max_rate        <= hac_pkg::MaxRateReset;
            cfg_reg.max_rate_step   <= hac_pkg::MaxRateStepReset;
            cfg_reg.align_tolerance <= hac_pkg::AlignToleranceReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/hac_product.sv =====
// Input register and gain product stage: error and gyro terms, floor ramp product, zone tests.
`timescale 1ns / 1ps

module hac_product (
    input  logic                clk,
    input  logic                rst_n,
    input  hac_pkg::hac_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hac_pkg::hac_item_t  in_item,
    output logic                out_valid,
    input  logic                out_ready,
    output hac_pkg::hac_prod_t  out_prod
);

    logic               item_valid_reg;
    hac_pkg::hac_item_t item_reg;
    logic               prod_valid_reg;
    hac_pkg::hac_prod_t prod_reg;
    hac_pkg::hac_prod_t prod_next;

    logic               item_ready;
    logic               prod_ready;
    logic        [14:0] err_abs;
    logic        [15:0] slow_limit;
    logic signed [31:0] prop_full;
    logic signed [31:0] damp_full;
    logic               aligned;

    assign prod_ready = !prod_valid_reg || out_ready;
    assign item_ready = !item_valid_reg || prod_ready;
    assign in_ready   = item_ready;

    always_comb
    begin
        // sign bit set means the magnitude is the two's complement negation
        err_abs    = item_reg.heading_error[14] ? 15'(-item_reg.heading_error)
                                                : 15'(item_reg.heading_error);
        slow_limit = {2'b00, cfg.align_tolerance} + {1'b0, cfg.align_tolerance, 1'b0};
        aligned    = {1'b0, err_abs} < {2'b00, cfg.align_tolerance};
        prop_full  = $signed({1'b0, cfg.prop_gain}) * item_reg.heading_error;
        damp_full  = $signed({1'b0, cfg.damp_gain}) * item_reg.yaw_rate;

        prod_next.prop_term  = prop_full[30:0];
        prod_next.damp_term  = item_reg.gyro_fresh ? damp_full : 32'sd0;
        prod_next.ramp_term  = cfg.min_ramp_gain * err_abs;
        prod_next.ramp_band  = {1'b0, err_abs} < slow_limit;
        prod_next.aligned    = aligned;
        prod_next.force_zero = item_reg.hold || aligned;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            prod_valid_reg <= 1'b0;
        end
        else
        begin
            if (item_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (prod_ready)
            begin
                prod_valid_reg <= item_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && item_ready)
        begin
            item_reg <= in_item;
        end
        if (item_valid_reg && prod_ready)
        begin
            prod_reg <= prod_next;
        end
    end

    assign out_valid = prod_valid_reg;
    assign out_prod  = prod_reg;

endmodule

// ===== sv/hac_shape.sv =====
// Command shaping: PD sum, rounding to Q4.12, floor with slow-zone ramp, magnitude clamp.
`timescale 1ns / 1ps

module hac_shape (
    input  logic                clk,
    input  logic                rst_n,
    input  hac_pkg::hac_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hac_pkg::hac_prod_t  in_prod,
    output logic                out_valid,
    input  logic                out_ready,
    output hac_pkg::hac_cmd_t   out_cmd
);

    logic               acc_valid_reg;
    hac_pkg::hac_acc_t  acc_reg;
    hac_pkg::hac_acc_t  acc_next;
    logic               cmd_valid_reg;
    hac_pkg::hac_cmd_t  cmd_reg;
    hac_pkg::hac_cmd_t  cmd_next;

    logic               acc_ready;
    logic               cmd_ready;
    logic        [31:0] ramp_round;
    logic        [23:0] ramp_rate;
    logic        [32:0] acc_abs;
    logic        [33:0] mag_round;
    logic        [25:0] mag_full;
    logic        [25:0] mag_floored;
    logic        [14:0] mag_clamped;

    assign cmd_ready = !cmd_valid_reg || out_ready;
    assign acc_ready = !acc_valid_reg || cmd_ready;
    assign in_ready  = acc_ready;

    always_comb
    begin
        ramp_round = {1'b0, in_prod.ramp_term} + 32'd128;
        ramp_rate  = ramp_round[31:8];

        acc_next.acc = 33'(in_prod.prop_term) - 33'(in_prod.damp_term);
        if (in_prod.ramp_band && (ramp_rate < {9'd0, cfg.min_rate}))
        begin
            acc_next.floor_rate = ramp_rate[14:0];
        end
        else
        begin
            acc_next.floor_rate = cfg.min_rate;
        end
        acc_next.aligned    = in_prod.aligned;
        acc_next.force_zero = in_prod.force_zero;
    end

    always_comb
    begin
        acc_abs   = acc_reg.acc[32] ? 33'(-acc_reg.acc) : 33'(acc_reg.acc);
        // round half away from zero on the magnitude
        mag_round = {1'b0, acc_abs} + 34'd128;
        mag_full  = mag_round[33:8];

        mag_floored = (mag_full < {11'd0, acc_reg.floor_rate}) ? {11'd0, acc_reg.floor_rate}
                                                               : mag_full;
        mag_clamped = (mag_floored > {11'd0, cfg.max_rate}) ? cfg.max_rate
                                                            : mag_floored[14:0];

        cmd_next.cmd        = acc_reg.acc[32] ? -$signed({1'b0, mag_clamped})
                                              : $signed({1'b0, mag_clamped});
        cmd_next.aligned    = acc_reg.aligned;
        cmd_next.force_zero = acc_reg.force_zero;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_valid_reg <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            if (acc_ready)
            begin
                acc_valid_reg <= in_valid;
            end
            if (cmd_ready)
            begin
                cmd_valid_reg <= acc_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && acc_ready)
        begin
            acc_reg <= acc_next;
        end
        if (acc_valid_reg && cmd_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end

    assign out_valid = cmd_valid_reg;
    assign out_cmd   = cmd_reg;

endmodule

// ===== sv/hac_slew.sv =====
// Slew limit against the previous command, hold/aligned zeroing, and the result register.
`timescale 1ns / 1ps

module hac_slew (
    input  logic                clk,
    input  logic                rst_n,
    input  hac_pkg::hac_cfg_t   cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  hac_pkg::hac_cmd_t   in_cmd,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [15:0]  rate_command,
    output logic                aligned
);

    logic               out_valid_reg;
    logic signed [15:0] prev_cmd_reg;
    logic signed [15:0] prev_cmd_next;
    logic signed [15:0] rate_command_reg;
    logic               aligned_reg;

    logic               load;
    logic signed [16:0] step_hi;
    logic signed [16:0] step_lo;
    logic signed [16:0] cmd_ext;

    assign in_ready = !out_valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb
    begin
        cmd_ext = 17'(in_cmd.cmd);
        step_hi = 17'(prev_cmd_reg) + $signed({2'b00, cfg.max_rate_step});
        step_lo = 17'(prev_cmd_reg) - $signed({2'b00, cfg.max_rate_step});
        if (in_cmd.force_zero)
        begin
            prev_cmd_next = 16'sd0;
        end
        else if (cmd_ext > step_hi)
        begin
            prev_cmd_next = step_hi[15:0];
        end
        else if (cmd_ext < step_lo)
        begin
            prev_cmd_next = step_lo[15:0];
        end
        else
        begin
            prev_cmd_next = in_cmd.cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            prev_cmd_reg  <= 16'sd0;
        end
        else
        begin
            if (in_ready)
            begin
                out_valid_reg <= in_valid;
            end
            if (load)
            begin
                prev_cmd_reg <= prev_cmd_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            rate_command_reg <= prev_cmd_next;
            aligned_reg      <= in_cmd.aligned;
        end
    end

    assign out_valid    = out_valid_reg;
    assign rate_command = rate_command_reg;
    assign aligned      = aligned_reg;

endmodule

// ===== sv/heading_align_rate_controller.sv =====
// Top level of the heading alignment rate controller: PD law, floor, clamp and slew limit.
//
//  channel   direction  signals                          request contents
//  s_axis    in         s_axis_tvalid/tready/tdata[39:0] heading_error, yaw_rate, flags
//  m_axis    out        m_axis_tvalid/tready/tdata[23:0] rate_command, aligned
//  cfg       in         cfg_we, cfg_index[2:0], cfg_data  one register write per cycle
//
// One request enters per cycle unless a stalled m_axis has filled every stage; each result passes through
// the input register, gain products, PD sum and floor, round and clamp, slew and result register.
// Only the slew stage reads the previous command, so back-to-back requests chain correctly.
// Reset clears all stage valids, the previous command, and loads the register defaults.
// A stalled m_axis holds each stage in place; s_axis_tready drops once every stage is full.
`timescale 1ns / 1ps

module heading_align_rate_controller (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // [14:0] heading_error, [30:15] yaw_rate, [31] gyro_fresh, [32] hold, [39:33] zero
    input  logic [hac_pkg::InDataWidth-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // [15:0] rate_command, [16] aligned, [23:17] zero
    output logic [hac_pkg::OutDataWidth-1:0]    m_axis_tdata,
    input  logic                                cfg_we,
    input  logic [hac_pkg::CfgIndexWidth-1:0]   cfg_index,
    input  logic [hac_pkg::CfgDataWidth-1:0]    cfg_data
);

    hac_pkg::hac_cfg_t  cfg;
    hac_pkg::hac_item_t in_item;
    hac_pkg::hac_prod_t prod;
    hac_pkg::hac_cmd_t  cmd;

    logic               prod_valid;
    logic               prod_ready;
    logic               cmd_valid;
    logic               cmd_ready;
    logic signed [15:0] rate_command;
    logic               aligned;

    assign in_item.heading_error = $signed(s_axis_tdata[14:0]);
    assign in_item.yaw_rate      = $signed(s_axis_tdata[30:15]);
    assign in_item.gyro_fresh    = s_axis_tdata[31];
    assign in_item.hold          = s_axis_tdata[32];

    hac_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hac_product u_product (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_item   (in_item),
        .out_valid (prod_valid),
        .out_ready (prod_ready),
        .out_prod  (prod)
    );

    hac_shape u_shape (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (prod_valid),
        .in_ready  (prod_ready),
        .in_prod   (prod),
        .out_valid (cmd_valid),
        .out_ready (cmd_ready),
        .out_cmd   (cmd)
    );

    hac_slew u_slew (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (cmd_valid),
        .in_ready     (cmd_ready),
        .in_cmd       (cmd),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .rate_command (rate_command),
        .aligned      (aligned)
    );

    assign m_axis_tdata = {7'd0, aligned, rate_command};

endmodule
